[rtl/core/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the serial packet deframer: word formats,
// mode and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

  // default payload buffer size in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 128;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  // configuration reset values
  localparam logic [7:0] SYNC_FIRST_RST  = 8'd147;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd224;

  // input modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_CKSUM   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  // saturation value of a reported bad length
  localparam logic [6:0] LEN_SAT = 7'd127;

  // input word
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } spd_in_t;

  // output word
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] packet_id;
    logic [7:0] packet_type;
    logic [6:0] payload_length;
    logic [7:0] read_data;
  } spd_out_t;

  // result waiting for the buffer read data
  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic [7:0] packet_id;
    logic [7:0] packet_type;
    logic [6:0] payload_length;
    logic       rd_en;
  } spd_stage_t;

endpackage

`default_nettype wire

[rtl/core/spd_ram.sv]
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/spd_parser.sv]
// ----------------------------------------------------------------------------
// spd_parser
// Frame state machine: sync hunt, header, payload write into the buffer,
// running sums and check, plus read requests into the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_parser
  import spd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [7:0]                      sync_first_i,
  input  wire logic [7:0]                      sync_second_i,
  input  wire logic                            in_valid_i,
  input  wire spd_in_t                         in_data_i,
  output      logic                            in_stall_o,
  input  wire logic                            adv_i,
  output      spd_stage_t                      stage_o,
  output      logic                            ram_we_o,
  output      logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr_o,
  output      logic [7:0]                      ram_wdata_o,
  output      logic                            ram_re_o,
  output      logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [8:0] LenLimit = 9'(BUFFER_BYTES - 8);
  localparam logic [8:0] BufLimit = 9'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_ID, PH_TYPE, PH_LEN, PH_PAYLOAD, PH_CHECK0, PH_CHECK1
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] id_q, id_d;
  logic [7:0] type_q, type_d;
  logic [6:0] len_q, len_d;
  logic [6:0] cnt_q, cnt_d;
  logic [7:0] sum_lo_q, sum_lo_d;
  logic [7:0] sum_hi_q, sum_hi_d;
  logic [7:0] chk0_q, chk0_d;
  spd_stage_t stage_q, stage_d;

  logic       accept;
  logic [7:0] rx;
  logic [7:0] sum_lo_add;
  logic [7:0] sum_hi_add;
  logic [6:0] cnt_inc;
  logic       len_bad;
  logic [8:0] cnt_ext;
  logic [8:0] ri_ext;

  // the stage register can only be refilled when its word moves on
  assign in_stall_o = stage_q.valid && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign rx         = in_data_i.rx_byte;

  // running sums and payload counter
  assign sum_lo_add = sum_lo_q + rx;
  assign sum_hi_add = sum_hi_q + sum_lo_add;
  assign cnt_inc    = cnt_q + 7'd1;

  // length byte screening
  assign len_bad = (rx == 8'd0) || (rx == sync_first_i) || (rx == sync_second_i) ||
                   ({1'b0, rx} > LenLimit) || rx[7];

  // buffer addresses; a payload write and a read never share a cycle
  assign cnt_ext     = {2'b00, cnt_q};
  assign ri_ext      = {2'b00, in_data_i.read_index};
  assign ram_waddr_o = cnt_ext[AW-1:0];
  assign ram_wdata_o = rx;
  assign ram_raddr_o = ri_ext[AW-1:0];
  assign ram_we_o    = accept && (in_data_i.mode == MODE_BYTE) && (phase_q == PH_PAYLOAD);
  assign ram_re_o    = accept && (in_data_i.mode == MODE_READ);

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    id_d     = id_q;
    type_d   = type_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    sum_lo_d = sum_lo_q;
    sum_hi_d = sum_hi_q;
    chk0_d   = chk0_q;

    stage_d                = '0;
    stage_d.packet_id      = id_q;
    stage_d.packet_type    = type_q;
    stage_d.payload_length = len_q;

    if (in_data_i.mode == MODE_BYTE) begin
      unique case (phase_q)
        PH_SYNC1: begin
          if (rx == sync_first_i) begin
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx == sync_second_i) begin
            phase_d  = PH_ID;
            id_d     = '0;
            type_d   = '0;
            len_d    = '0;
            cnt_d    = '0;
            sum_lo_d = '0;
            sum_hi_d = '0;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_ID: begin
          id_d     = rx;
          sum_lo_d = sum_lo_add;
          sum_hi_d = sum_hi_add;
          phase_d  = PH_TYPE;
        end
        PH_TYPE: begin
          type_d   = rx;
          sum_lo_d = sum_lo_add;
          sum_hi_d = sum_hi_add;
          phase_d  = PH_LEN;
        end
        PH_LEN: begin
          if (len_bad) begin
            stage_d.valid          = 1'b1;
            stage_d.status         = ST_BAD_LEN;
            stage_d.payload_length = rx[7] ? LEN_SAT : rx[6:0];
            phase_d                = PH_SYNC1;
          end else begin
            len_d   = rx[6:0];
            cnt_d   = '0;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_lo_d = sum_lo_add;
          sum_hi_d = sum_hi_add;
          cnt_d    = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CHECK0;
          end
        end
        PH_CHECK0: begin
          chk0_d  = rx;
          phase_d = PH_CHECK1;
        end
        PH_CHECK1: begin
          stage_d.valid  = 1'b1;
          stage_d.status = ((chk0_q == sum_lo_q) && (rx == sum_hi_q)) ? ST_OK : ST_CKSUM;
          phase_d        = PH_SYNC1;
        end
        default: begin
          phase_d = PH_SYNC1;
        end
      endcase
    end else if (in_data_i.mode == MODE_TIMEOUT) begin
      if ((phase_q != PH_SYNC1) && (phase_q != PH_SYNC2)) begin
        stage_d.valid  = 1'b1;
        stage_d.status = ST_TIMEOUT;
        phase_d        = PH_SYNC1;
      end
    end else if (in_data_i.mode == MODE_READ) begin
      stage_d.valid          = 1'b1;
      stage_d.status         = ST_READ;
      stage_d.packet_id      = '0;
      stage_d.packet_type    = '0;
      stage_d.payload_length = '0;
      stage_d.rd_en          = (ri_ext < BufLimit);
    end
  end

  // state and stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC1;
      id_q     <= '0;
      type_q   <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      sum_lo_q <= '0;
      sum_hi_q <= '0;
      chk0_q   <= '0;
      stage_q  <= '0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        id_q     <= id_d;
        type_q   <= type_d;
        len_q    <= len_d;
        cnt_q    <= cnt_d;
        sum_lo_q <= sum_lo_d;
        sum_hi_q <= sum_hi_d;
        chk0_q   <= chk0_d;
        stage_q  <= stage_d;
      end else if (adv_i) begin
        stage_q.valid <= 1'b0;
      end
    end
  end

  assign stage_o = stage_q;

  // payload counter stays below the announced length
  a_cnt_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (cnt_q < len_q))
    else $error("payload count reached length inside payload phase");

  // an accepted length never exceeds the buffer limit
  a_len_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> ({2'b00, len_q} <= LenLimit) && (len_q != 7'd0))
    else $error("payload length outside buffer limit");

  // last check byte always ends the frame with a result
  a_check_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.mode == MODE_BYTE) && (phase_q == PH_CHECK1))
      |=> stage_q.valid && (phase_q == PH_SYNC1) &&
          ((stage_q.status == ST_OK) || (stage_q.status == ST_CKSUM)))
    else $error("check byte did not produce a frame result");

  // a read request yields a read word and leaves the frame state alone
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.mode == MODE_READ))
      |=> stage_q.valid && (stage_q.status == ST_READ) && $stable(phase_q))
    else $error("read request mishandled");

endmodule

`default_nettype wire

[rtl/core/spd_out_stage.sv]
// ----------------------------------------------------------------------------
// spd_out_stage
// Output register: merges the buffer read data into the staged result and
// holds the word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_out_stage
  import spd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire spd_stage_t stage_i,
  input  wire logic [7:0] ram_rdata_i,
  input  wire logic       out_stall_i,
  output      logic       out_valid_o,
  output      spd_out_t   out_data_o,
  output      logic       adv_o
);

  logic     out_valid_q;
  spd_out_t out_data_q;
  spd_out_t out_data_d;

  // output register is free or being emptied this cycle
  assign adv_o = !out_valid_q || !out_stall_i;

  // build the word from the stage and the buffer data
  always_comb begin
    out_data_d.status         = stage_i.status;
    out_data_d.packet_id      = stage_i.packet_id;
    out_data_d.packet_type    = stage_i.packet_type;
    out_data_d.payload_length = stage_i.payload_length;
    out_data_d.read_data      = stage_i.rd_en ? ram_rdata_i : 8'd0;
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= stage_i.valid;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (adv_o && stage_i.valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[rtl/core/serial_packet_deframer.sv]
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Hunts two sync bytes, takes id, type, length, payload and two check bytes
// with running 8-bit sums, keeps the payload in a buffer and reports each
// frame outcome; read words return stored payload bytes.
//
//   channel  direction  handshake               word
//   in       input      in_valid_i / in_stall_o  spd_in_t
//   out      output     out_valid_o / out_stall_i spd_out_t
//   cfg      input      cfg_valid_i / cfg_ready_o index + 8-bit data
//
// One word is taken per cycle when the output side keeps up; a result
// passes through the stage register, alongside the buffer read, and then
// through the output register.
// Reset clears the frame state and sets the sync registers to defaults;
// the payload buffer is not cleared.
// A stalled output register backs up the stage register, which then stalls
// the input in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_packet_deframer
  import spd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire spd_in_t              in_data_i,
  output      logic                 in_stall_o,
  output      logic                 out_valid_o,
  output      spd_out_t             out_data_o,
  input  wire logic                 out_stall_i,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic [7:0]    sync_first_q;
  logic [7:0]    sync_second_q;
  logic          adv;
  spd_stage_t    stage;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        REG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame state machine
  spd_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sync_first_i (sync_first_q),
    .sync_second_i(sync_second_q),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .adv_i        (adv),
    .stage_o      (stage),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  // payload buffer
  spd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register
  spd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage),
    .ram_rdata_i(ram_rdata),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .adv_o      (adv)
  );

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for serial_packet_deframer. Frames, broken frames,
// timeouts, noise and payload reads are pushed through the input channel
// under random pacing on both sides. An in-bench deframer predicts every
// report, and each output word is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import spd_pkg::*;

  localparam int unsigned BUF_BYTES     = BUFFER_BYTES_DEF;
  localparam int unsigned MAX_LEN       = BUF_BYTES - 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned RANDOM_WORDS  = 500;
  localparam longint      LIMIT_NS      = 10_000_000;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_ID, GET_TYPE, GET_LEN, GET_PAYLOAD, GET_CHECK_LO,
    GET_CHECK_HI
  } frame_phase_e;

  typedef enum int {
    FLAW_NONE, FLAW_CHECK_LO, FLAW_CHECK_HI, FLAW_CUT, FLAW_BAD_LEN
  } frame_flaw_e;

  // dut ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  spd_in_t              in_data_i   = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  spd_out_t             out_data_o;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]           cfg_data_i  = '0;

  // predicted deframer state and settings
  logic [7:0]   sync_a = SYNC_FIRST_RST;
  logic [7:0]   sync_b = SYNC_SECOND_RST;
  frame_phase_e ph = HUNT_FIRST;
  logic [7:0]   hold_id = '0;
  logic [7:0]   hold_type = '0;
  logic [6:0]   hold_len = '0;
  logic [6:0]   pay_cnt = '0;
  logic [7:0]   sum_lo = '0;
  logic [7:0]   sum_hi = '0;
  logic [7:0]   first_chk = '0;
  logic [7:0]   shadow_payload [BUF_BYTES];
  int           stored_span = 0;

  spd_out_t pending_reports [$];
  int       errors = 0;
  int       words_sent = 0;
  bit       tx_gaps = 1'b0;
  bit       rx_stalls = 1'b0;
  bit       hold_request = 1'b0;

  serial_packet_deframer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // small payloads mostly, a few up to the buffer limit
  function automatic logic [7:0] pick_len();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, MAX_LEN))
                                       : 8'($urandom_range(1, 16));
  endfunction

  // running two-level 8-bit sum
  function automatic void fold_sum(inout logic [7:0] lo, inout logic [7:0] hi,
                                   input logic [7:0] b);
    lo = lo + b;
    hi = hi + lo;
  endfunction

  // advance the predicted deframer by one word, return 1 when it reports
  function automatic bit predict_report(input spd_in_t w, output spd_out_t r);
    logic [7:0] b;
    b = w.rx_byte;
    r = '0;
    case (w.mode)
      MODE_BYTE: begin
        case (ph)
          HUNT_FIRST: begin
            if (b == sync_a) ph = HUNT_SECOND;
          end
          HUNT_SECOND: begin
            // a wrong second sync is used up, not retried as a first one
            if (b == sync_b) begin
              ph = GET_ID;
              hold_id = '0;
              hold_type = '0;
              hold_len = '0;
              pay_cnt = '0;
              sum_lo = '0;
              sum_hi = '0;
            end else begin
              ph = HUNT_FIRST;
            end
          end
          GET_ID: begin
            hold_id = b;
            fold_sum(sum_lo, sum_hi, b);
            ph = GET_TYPE;
          end
          GET_TYPE: begin
            hold_type = b;
            fold_sum(sum_lo, sum_hi, b);
            ph = GET_LEN;
          end
          GET_LEN: begin
            if (b == 8'd0 || b == sync_a || b == sync_b || b > 8'(MAX_LEN) || b > 8'd127) begin
              r.status = ST_BAD_LEN;
              r.packet_id = hold_id;
              r.packet_type = hold_type;
              r.payload_length = (b > 8'd127) ? LEN_SAT : b[6:0];
              ph = HUNT_FIRST;
              return 1'b1;
            end
            hold_len = b[6:0];
            pay_cnt = '0;
            ph = GET_PAYLOAD;
          end
          GET_PAYLOAD: begin
            shadow_payload[pay_cnt] = b;
            if (int'(pay_cnt) + 1 > stored_span) stored_span = int'(pay_cnt) + 1;
            fold_sum(sum_lo, sum_hi, b);
            pay_cnt = pay_cnt + 7'd1;
            if (pay_cnt >= hold_len) ph = GET_CHECK_LO;
          end
          GET_CHECK_LO: begin
            first_chk = b;
            ph = GET_CHECK_HI;
          end
          default: begin
            r.status = (first_chk == sum_lo && b == sum_hi) ? ST_OK : ST_CKSUM;
            r.packet_id = hold_id;
            r.packet_type = hold_type;
            r.payload_length = hold_len;
            ph = HUNT_FIRST;
            return 1'b1;
          end
        endcase
        return 1'b0;
      end
      MODE_TIMEOUT: begin
        // only abandons a frame once both sync bytes are in
        if (ph >= GET_ID) begin
          r.status = ST_TIMEOUT;
          r.packet_id = hold_id;
          r.packet_type = hold_type;
          r.payload_length = hold_len;
          ph = HUNT_FIRST;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_READ: begin
        r.status = ST_READ;
        r.read_data = shadow_payload[w.read_index];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // compare each output word with the oldest predicted report
  always @(posedge clk_i) begin : report_check
    spd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word: status %0d", out_data_o.status);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 8'(want.status), 8'(out_data_o.status));
        check_field("packet_id", want.packet_id, out_data_o.packet_id);
        check_field("packet_type", want.packet_type, out_data_o.packet_type);
        check_field("payload_length", 8'(want.payload_length),
                    8'(out_data_o.payload_length));
        check_field("read_data", want.read_data, out_data_o.read_data);
      end
    end
  end

  // output stall pacing, with a long hold-off on request
  initial begin : rx_pacing
    int n;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        n = pick_gap();
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // offer one word, wait until taken, then predict its report
  task automatic send_word(input spd_in_t w);
    int       gap;
    spd_out_t r;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_report(w, r)) pending_reports.push_back(r);
    if (w.mode != MODE_SPARE) words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    spd_in_t w;
    w.mode = MODE_BYTE;
    w.rx_byte = b;
    w.read_index = 7'($urandom);
    send_word(w);
  endtask

  task automatic send_mode(input logic [1:0] mode, input logic [6:0] idx);
    spd_in_t w;
    w.mode = mode;
    w.rx_byte = 8'($urandom);
    w.read_index = idx;
    send_word(w);
  endtask

  // read back a payload position that some frame has written
  task automatic send_read_stored();
    if (stored_span > 0) send_mode(MODE_READ, 7'($urandom_range(0, stored_span - 1)));
  endtask

  // one frame with random payload, optionally damaged
  task automatic send_frame(input logic [7:0] id, input logic [7:0] kind, input logic [7:0] len,
                            input frame_flaw_e flaw, input int cut_at);
    logic [7:0] body [$];
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] b;
    // bring the deframer back to hunting first
    if (ph == HUNT_SECOND) send_byte(sync_b + 8'd1);
    else if (ph != HUNT_FIRST) send_mode(MODE_TIMEOUT, 7'($urandom));
    lo = '0;
    hi = '0;
    body.push_back(id);
    fold_sum(lo, hi, id);
    body.push_back(kind);
    fold_sum(lo, hi, kind);
    body.push_back(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      body.push_back(b);
      fold_sum(lo, hi, b);
    end
    body.push_back(lo);
    body.push_back(hi);
    case (flaw)
      FLAW_CHECK_LO: body[len + 3] = body[len + 3] ^ 8'($urandom_range(1, 255));
      FLAW_CHECK_HI: body[len + 4] = body[len + 4] ^ 8'($urandom_range(1, 255));
      FLAW_BAD_LEN:  while (body.size() > 3) void'(body.pop_back());
      FLAW_CUT:      while (body.size() > cut_at) void'(body.pop_back());
      default: ;
    endcase
    send_byte(sync_a);
    send_byte(sync_b);
    foreach (body[i]) send_byte(body[i]);
    if (flaw == FLAW_CUT) send_mode(MODE_TIMEOUT, 7'($urandom));
  endtask

  // let all reports drain and the pipeline empty out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SYNC_FIRST) sync_a = value;
    else sync_b = value;
  endtask

  // shortest and longest payloads, id/type extremes, read back both ends
  task automatic test_good_frames();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_frame(8'h00, 8'hff, 8'd1, FLAW_NONE, 0);
    send_mode(MODE_READ, 7'd0);
    send_frame(8'hff, 8'h00, 8'(MAX_LEN), FLAW_NONE, 0);
    send_mode(MODE_READ, 7'd0);
    send_mode(MODE_READ, 7'(MAX_LEN - 1));
    send_mode(MODE_READ, 7'd64);
  endtask

  // corrupt either check byte
  task automatic test_checksum_errors();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    send_frame(8'h12, 8'h34, 8'd3, FLAW_CHECK_LO, 0);
    send_frame(8'h56, 8'h78, 8'd4, FLAW_CHECK_HI, 0);
  endtask

  // zero, sync values, just over the buffer limit, saturation
  task automatic test_bad_lengths();
    send_frame(8'h01, 8'h02, 8'd0, FLAW_BAD_LEN, 0);
    send_frame(8'h03, 8'h04, sync_a, FLAW_BAD_LEN, 0);
    send_frame(8'h05, 8'h06, sync_b, FLAW_BAD_LEN, 0);
    send_frame(8'h07, 8'h08, 8'(MAX_LEN + 1), FLAW_BAD_LEN, 0);
    send_frame(8'h09, 8'h0a, 8'd127, FLAW_BAD_LEN, 0);
    send_frame(8'h0b, 8'h0c, 8'd128, FLAW_BAD_LEN, 0);
    send_frame(8'h0d, 8'h0e, 8'd255, FLAW_BAD_LEN, 0);
  endtask

  // timeouts and sync mismatches before a frame has started, unused mode
  task automatic test_sync_hunting();
    settle();
    send_mode(MODE_TIMEOUT, 7'h7f);
    // timeout between the sync bytes leaves the hunt where it was
    send_byte(sync_a);
    send_mode(MODE_TIMEOUT, 7'h00);
    send_byte(sync_b);
    send_byte(8'h5a);
    send_mode(MODE_TIMEOUT, 7'h55);
    // first sync repeated: the second copy is not taken as a new start
    send_byte(sync_a);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'h11);
    send_mode(MODE_TIMEOUT, 7'h2a);
    send_mode(MODE_SPARE, 7'h7f);
    send_mode(MODE_SPARE, 7'h00);
  endtask

  // abandon a frame at every point after sync
  task automatic test_timeouts();
    for (int k = 0; k <= 6; k++) send_frame(8'(8'h20 + k), 8'(8'h40 + k), 8'd2, FLAW_CUT, k);
  endtask

  // sync registers at extremes, equal, and low enough to clash with lengths
  task automatic test_sync_settings();
    logic [7:0] pairs [4][2];
    pairs = '{'{8'h00, 8'hff}, '{8'hff, 8'h00}, '{8'h7e, 8'h7e}, '{8'h05, 8'h0a}};
    for (int p = 0; p < 4; p++) begin
      write_sync(REG_SYNC_FIRST, pairs[p][0]);
      write_sync(REG_SYNC_SECOND, pairs[p][1]);
      send_frame(8'($urandom), 8'($urandom), pick_len(), FLAW_NONE, 0);
      send_frame(8'($urandom), 8'($urandom), sync_a, FLAW_BAD_LEN, 0);
      send_frame(8'($urandom), 8'($urandom), sync_b, FLAW_BAD_LEN, 0);
      send_frame(8'($urandom), 8'($urandom), pick_len(), FLAW_CHECK_LO, 0);
      send_read_stored();
    end
  endtask

  // receiver holds off long enough for the input to back up
  task automatic test_output_hold();
    settle();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_request = 1'b1;
    repeat (24) send_read_stored();
    send_frame(8'($urandom), 8'($urandom), 8'd3, FLAW_NONE, 0);
    repeat (8) send_read_stored();
    settle();
  endtask

  // mostly well-formed frames with random content, plus damage and noise
  task automatic test_random_traffic();
    int goal;
    int sel;
    int len;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_sync(REG_SYNC_FIRST, SYNC_FIRST_RST);
          write_sync(REG_SYNC_SECOND, SYNC_SECOND_RST);
        end
        2: begin
          write_sync(REG_SYNC_FIRST, 8'hff);
          write_sync(REG_SYNC_SECOND, 8'h00);
        end
        default: begin
          write_sync(REG_SYNC_FIRST, 8'($urandom));
          write_sync(REG_SYNC_SECOND, 8'($urandom));
        end
      endcase
      tx_gaps = (p != 1);
      rx_stalls = (p != 1);
      goal = words_sent + RANDOM_WORDS / 4;
      while (words_sent < goal) begin
        sel = $urandom_range(0, 99);
        len = int'(pick_len());
        if (sel < 60) begin
          send_frame(8'($urandom), 8'($urandom), 8'(len), FLAW_NONE, 0);
        end else if (sel < 70) begin
          send_frame(8'($urandom), 8'($urandom), 8'(len),
                     $urandom_range(0, 1) ? FLAW_CHECK_LO : FLAW_CHECK_HI, 0);
        end else if (sel < 76) begin
          send_frame(8'($urandom), 8'($urandom), 8'(len), FLAW_CUT,
                     $urandom_range(0, len + 4));
        end else if (sel < 80) begin
          case ($urandom_range(0, 3))
            0: len = 0;
            1: len = int'(sync_a);
            2: len = int'(sync_b);
            default: len = $urandom_range(MAX_LEN + 1, 255);
          endcase
          send_frame(8'($urandom), 8'($urandom), 8'(len), FLAW_BAD_LEN, 0);
        end else if (sel < 90) begin
          repeat ($urandom_range(1, 4)) send_read_stored();
        end else if (sel < 94) begin
          send_mode(MODE_TIMEOUT, 7'($urandom));
        end else if (sel < 98) begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        end else begin
          send_mode(MODE_SPARE, 7'($urandom));
        end
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_frames();
    test_checksum_errors();
    test_bad_lengths();
    test_sync_hunting();
    test_timeouts();
    test_sync_settings();
    test_output_hold();
    test_random_traffic();
    settle();
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
